// File: sv/csm_pkg.sv
// Shared constants for the column scatter max/argmax block.
// No dependencies; imported by column_scatter_max_argmax and tb_top.
`default_nettype none

package csm_pkg;

    // Item kinds carried in the low bits of s_tuser.
    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // Fixed field widths.
    localparam int KIND_BITS     = 2;
    localparam int COLUMN_BITS   = 10;
    localparam int NUM_COLS_BITS = 11;

    // Column count after reset.
    localparam logic [NUM_COLS_BITS-1:0] NUM_COLS_RESET = 11'd1024;

    // Width of the clear generation tag kept with every column entry.
    localparam int EPOCH_BITS = 8;

    typedef logic [EPOCH_BITS-1:0] epoch_t;

    // Tag written by the clearing sweep; never equal to a live generation.
    localparam epoch_t EPOCH_EMPTY = '0;
    localparam epoch_t EPOCH_FIRST = epoch_t'(1);
    localparam epoch_t EPOCH_LAST  = '1;

endpackage

`default_nettype wire

// File: sv/csm_mem.sv
// Column state memory: one write port, one read port with registered data.
// Uses no package items; instantiated by column_scatter_max_argmax.
`default_nettype none

module csm_mem #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 57,
    parameter int ADDR_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Synchronous write and read; a read of the address being written
    // returns the old contents.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sv/csm_out_buf.sv
// Two-word result queue that decouples the update pipeline from m_tready.
// Uses no package items; instantiated by column_scatter_max_argmax.
`default_nettype none

module csm_out_buf #(
    parameter int WIDTH = 50
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data,
    output logic      [1:0]       count
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/column_scatter_max_argmax.sv
// Top level of the column scatter max/argmax block.
// Depends on csm_pkg, csm_mem and csm_out_buf.
//
// Usage:
//   s_ channel: one word per item. s_tuser = {first_is_minus_infinity, kind}; kind 0 folds
//   an entry's sum first_value + second_value into its column (strictly greater wins,
//   so the earliest row keeps ties), kind 1 reads a column, kind 2 empties all columns.
//   m_ channel: one word per read item, in order: max_value, max_row, and
//   m_tuser = column_empty. Empty or out-of-range columns read back as 0, 0, 1.
//   cfg_ channel: writes num_cols (always ready); write it only while idle.
// Timing:
//   One item per cycle is accepted while s_tready is high; see Stalls. A read's result
//   passes through the compare stage register and the result queue before it reaches m_.
//   Each item makes one pass through a registered read of the column memory followed
//   by a compare and write-back; a forwarding register covers back-to-back items on
//   the same column.
//   Clears bump a generation tag kept with each entry. Every 255th clear, and reset,
//   start a clearing sweep over all MAX_COLS columns during which s_tready is low.
// Stalls:
//   A two-word result queue absorbs m_tready low; besides sweeps and the clear that starts
//   one, s_tready drops only when that queue and a read in flight would fill it. Reset
//   empties every column and sets num_cols to 1024.
`default_nettype none

module column_scatter_max_argmax
    import csm_pkg::*;
#(
    parameter int MAX_COLS   = 1024,
    parameter int ROW_BITS   = 16,
    parameter int VALUE_BITS = 32,
    localparam int S_DATA_W  = ((COLUMN_BITS + ROW_BITS + 2 * VALUE_BITS + 7) / 8) * 8,
    localparam int M_DATA_W  = ((VALUE_BITS + 1 + ROW_BITS + 7) / 8) * 8
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // Input items.
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // s_tdata: column, row_index, first_value, second_value, zero pad.
    input  wire logic [S_DATA_W-1:0]      s_tdata,
    // s_tuser: kind, first_is_minus_infinity.
    input  wire logic [KIND_BITS:0]       s_tuser,
    // Results.
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // m_tdata: max_value, max_row, zero pad.
    output logic      [M_DATA_W-1:0]      m_tdata,
    // m_tuser: column_empty.
    output logic                          m_tuser,
    // Column count register.
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [NUM_COLS_BITS-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int SUM_W  = VALUE_BITS + 1;
    localparam int WORD_W = EPOCH_BITS + SUM_W + ROW_BITS;
    localparam int RES_W  = SUM_W + ROW_BITS + 1;

    localparam int OFS_ROW = COLUMN_BITS;
    localparam int OFS_FV  = OFS_ROW + ROW_BITS;
    localparam int OFS_SV  = OFS_FV + VALUE_BITS;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_COLS - 1);

    // Controller states.
    localparam logic ST_SWEEP = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    // Input field unpacking.
    logic [KIND_BITS-1:0]   in_kind;
    logic                   in_minf;
    logic [COLUMN_BITS-1:0] in_column;
    logic [ROW_BITS-1:0]    in_row;
    logic [VALUE_BITS-1:0]  in_first;
    logic [VALUE_BITS-1:0]  in_second;
    logic [SUM_W-1:0]       in_sum;
    logic                   in_range;
    logic                   accept;

    // Control and configuration state.
    logic                     state_reg;
    logic                     state_next;
    logic [ADDR_W-1:0]        sweep_addr_reg;
    logic [ADDR_W-1:0]        sweep_addr_next;
    epoch_t                   epoch_reg;
    epoch_t                   epoch_next;
    logic [NUM_COLS_BITS-1:0] num_cols_reg;

    // Compare stage registers.
    logic                 s1_valid_reg;
    logic [KIND_BITS-1:0] s1_kind_reg;
    logic [ADDR_W-1:0]    s1_addr_reg;
    logic                 s1_range_reg;
    logic                 s1_minf_reg;
    logic [ROW_BITS-1:0]  s1_row_reg;
    logic [SUM_W-1:0]     s1_sum_reg;

    // Forwarding of the last write-back.
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [WORD_W-1:0] fwd_word_reg;

    // Memory and result queue wiring.
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] cur_word;
    epoch_t            cur_tag;
    logic [SUM_W-1:0]  cur_sum;
    logic [ROW_BITS-1:0] cur_row;
    logic              cur_filled;
    logic              upd_wr;
    logic              mem_wr;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_word;
    logic              res_push;
    logic [RES_W-1:0]  res_data;
    logic [RES_W-1:0]  out_data;
    logic [1:0]        out_count;
    logic [2:0]        occupancy;
    logic              s1_is_read;
    logic              s1_clear;
    logic              clear_wraps;

    assign in_kind   = s_tuser[KIND_BITS-1:0];
    assign in_minf   = s_tuser[KIND_BITS];
    assign in_column = s_tdata[COLUMN_BITS-1:0];
    assign in_row    = s_tdata[OFS_ROW +: ROW_BITS];
    assign in_first  = s_tdata[OFS_FV +: VALUE_BITS];
    assign in_second = s_tdata[OFS_SV +: VALUE_BITS];

    // Sum of the two addends, sign-extended by one bit so it cannot overflow.
    assign in_sum = {in_first[VALUE_BITS-1], in_first} + {in_second[VALUE_BITS-1], in_second};

    // A column counts only below num_cols and within the memory.
    assign in_range = ({1'b0, in_column} < num_cols_reg) && (32'(in_column) < 32'(MAX_COLS));

    // Input flow control: no intake during a sweep or when a clear will start
    // one, and no more reads than the result queue can hold.
    assign s1_is_read  = s1_valid_reg && (s1_kind_reg == KIND_READ);
    assign s1_clear    = s1_valid_reg && (s1_kind_reg == KIND_CLEAR);
    assign clear_wraps = s1_clear && (epoch_reg == EPOCH_LAST);
    assign occupancy   = {1'b0, out_count} + {2'b00, s1_is_read};
    assign s_tready    = (state_reg == ST_RUN) && !clear_wraps
                         && ((occupancy < 3'd2) || (m_tvalid && m_tready));
    assign accept      = s_tvalid && s_tready;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= NUM_COLS_RESET;
        end else if (cfg_valid) begin
            num_cols_reg <= cfg_data;
        end
    end

    // Capture the accepted item; its memory read is issued in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_kind_reg  <= in_kind;
            s1_addr_reg  <= ADDR_W'(in_column);
            s1_range_reg <= in_range;
            s1_minf_reg  <= in_minf;
            s1_row_reg   <= in_row;
            s1_sum_reg   <= in_sum;
        end
    end

    csm_mem #(
        .DEPTH  (MAX_COLS),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_word),
        .rd_en   (accept),
        .rd_addr (ADDR_W'(in_column)),
        .rd_data (rd_word)
    );

    // Pick the freshest copy of the column: the write-back of the previous
    // item if it hit the same column, otherwise the memory.
    assign cur_word = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_word_reg : rd_word;
    assign cur_tag  = cur_word[WORD_W-1 -: EPOCH_BITS];
    assign cur_sum  = cur_word[ROW_BITS +: SUM_W];
    assign cur_row  = cur_word[ROW_BITS-1:0];

    // A column holds data only if its tag matches the current generation.
    assign cur_filled = s1_range_reg && (cur_tag == epoch_reg);

    // Replace the stored maximum on an empty column or a strictly greater sum.
    assign upd_wr = s1_valid_reg && (s1_kind_reg == KIND_UPDATE) && s1_range_reg
                    && !s1_minf_reg
                    && (!cur_filled || ($signed(s1_sum_reg) > $signed(cur_sum)));

    // Write port: the sweep owns it while running, the compare stage otherwise.
    always_comb begin
        if (state_reg == ST_SWEEP) begin
            mem_wr      = 1'b1;
            mem_wr_addr = sweep_addr_reg;
            mem_wr_word = {EPOCH_EMPTY, {(SUM_W + ROW_BITS){1'b0}}};
        end else begin
            mem_wr      = upd_wr;
            mem_wr_addr = s1_addr_reg;
            mem_wr_word = {epoch_reg, s1_sum_reg, s1_row_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= upd_wr && (state_reg == ST_RUN);
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_wr) begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_word_reg <= mem_wr_word;
        end
    end

    // Read results: {column_empty, max_row, max_value}.
    assign res_push = s1_is_read;
    assign res_data = cur_filled ? {1'b0, cur_row, cur_sum}
                                 : {1'b1, {(ROW_BITS + SUM_W){1'b0}}};

    // Generation counter and clearing sweep.
    always_comb begin
        state_next      = state_reg;
        sweep_addr_next = sweep_addr_reg;
        epoch_next      = epoch_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
                if (sweep_addr_reg == LAST_ADDR) begin
                    state_next = ST_RUN;
                    epoch_next = EPOCH_FIRST;
                end
            end
            ST_RUN: begin
                sweep_addr_next = '0;
                if (clear_wraps) begin
                    state_next = ST_SWEEP;
                end else if (s1_clear) begin
                    epoch_next = epoch_reg + EPOCH_FIRST;
                end
            end
            default: begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            epoch_reg      <= EPOCH_FIRST;
        end else begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            epoch_reg      <= epoch_next;
        end
    end

    csm_out_buf #(
        .WIDTH (RES_W)
    ) u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data),
        .count     (out_count)
    );

    // Result word packing.
    assign m_tdata = M_DATA_W'(out_data[SUM_W + ROW_BITS - 1:0]);
    assign m_tuser = out_data[RES_W-1];

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for column_scatter_max_argmax: directed and random items with
// random idling on both streams, checked against an in-bench column peak predictor.
// Depends on csm_pkg and the column_scatter_max_argmax RTL.
`timescale 1ns / 100ps

module tb_top
    import csm_pkg::*;
();

    localparam int ROW_W     = 16;
    localparam int VAL_W     = 32;
    localparam int SUM_W     = VAL_W + 1;
    localparam int COLS      = 1024;
    localparam int S_DATA_W  = 96;
    localparam int M_DATA_W  = 56;
    localparam int CYCLE_LIMIT = 400000;

    // Kind code that the block ignores.
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [COLUMN_BITS-1:0] column;
        logic [ROW_W-1:0]       row;
        logic [VAL_W-1:0]       first;
        logic                   minus_inf;
        logic [VAL_W-1:0]       second;
    } entry_word_t;

    typedef struct packed {
        logic [SUM_W-1:0] peak_sum;
        logic [ROW_W-1:0] peak_row;
        logic             empty;
    } column_peak_t;

    // Predicts every column's peak sum and row, and checks read answers in order.
    class column_peak_board;
        logic [NUM_COLS_BITS-1:0] num_cols;
        bit                       filled [COLS];
        logic signed [SUM_W-1:0]  best_sum [COLS];
        logic [ROW_W-1:0]         best_row [COLS];
        column_peak_t             peak_queue [$];
        int mismatch_count;
        int word_count;
        int read_count;
        int clear_count;

        function new();
            num_cols = NUM_COLS_RESET;
            foreach (filled[i]) filled[i] = 1'b0;
        endfunction

        function void note_word(entry_word_t w);
            logic signed [SUM_W-1:0] sum;
            bit in_range;
            column_peak_t pk;
            word_count++;
            in_range = (w.column < num_cols);
            case (w.kind)
                KIND_UPDATE: begin
                    if (in_range && !w.minus_inf) begin
                        sum = $signed({w.first[VAL_W-1], w.first})
                            + $signed({w.second[VAL_W-1], w.second});
                        // Strictly greater replaces, so the earliest row keeps a tie.
                        if (!filled[w.column] || sum > best_sum[w.column]) begin
                            best_sum[w.column] = sum;
                            best_row[w.column] = w.row;
                            filled[w.column]   = 1'b1;
                        end
                    end
                end
                KIND_READ: begin
                    read_count++;
                    if (in_range && filled[w.column])
                        pk = '{best_sum[w.column], best_row[w.column], 1'b0};
                    else
                        pk = '{'0, '0, 1'b1};
                    peak_queue.push_back(pk);
                end
                KIND_CLEAR: begin
                    clear_count++;
                    foreach (filled[i]) filled[i] = 1'b0;
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH: %s", what);
            mismatch_count++;
        endtask

        task check_peak(logic [SUM_W-1:0] got_sum, logic [ROW_W-1:0] got_row,
                        logic got_empty);
            column_peak_t pk;
            if (peak_queue.size() == 0) begin
                report_mismatch("result word with no read outstanding");
                return;
            end
            pk = peak_queue.pop_front();
            if (got_sum !== pk.peak_sum)
                report_mismatch($sformatf("max_value %h, predicted %h", got_sum, pk.peak_sum));
            if (got_row !== pk.peak_row)
                report_mismatch($sformatf("max_row %h, predicted %h", got_row, pk.peak_row));
            if (got_empty !== pk.empty)
                report_mismatch($sformatf("column_empty %b, predicted %b", got_empty,
                                          pk.empty));
        endtask
    endclass

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_DATA_W-1:0]      s_tdata;
    logic [KIND_BITS:0]       s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_DATA_W-1:0]      m_tdata;
    logic                     m_tuser;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [NUM_COLS_BITS-1:0] cfg_data;

    column_peak_board board;
    int sender_idle_pct;
    int receiver_stall_pct;
    int cycle_count;
    int setting_count;

    // Memory of the last update, reused to build equal-sum ties.
    logic [COLUMN_BITS-1:0] last_column;
    logic [VAL_W-1:0]       last_first;
    logic [VAL_W-1:0]       last_second;

    always #5 aclk = ~aclk;

    column_scatter_max_argmax u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // column, row_index, first_value, second_value, pad
        .s_tuser   (s_tuser),   // kind, first_is_minus_infinity
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // max_value, max_row, pad
        .m_tuser   (m_tuser),   // column_empty
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Receiver backpressure, changed on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Result monitor: every accepted result word is checked at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_peak(m_tdata[SUM_W-1:0], m_tdata[SUM_W+ROW_W-1:SUM_W], m_tuser);
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Presents one word and returns at the falling edge after it is accepted.
    task drive_word(entry_word_t w);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, w.second, w.first, w.row, w.column};
        s_tuser  <= {w.minus_inf, w.kind};
        do @(posedge aclk); while (!s_tready);
        board.note_word(w);
        @(negedge aclk);
    endtask

    task send(logic [KIND_BITS-1:0] kind, logic [COLUMN_BITS-1:0] column,
              logic [ROW_W-1:0] row, logic [VAL_W-1:0] first, logic minus_inf,
              logic [VAL_W-1:0] second);
        entry_word_t w;
        w = '{kind, column, row, first, minus_inf, second};
        drive_word(w);
    endtask

    // Waits until every read has answered, the pipeline has emptied and no sweep runs.
    task wait_idle();
        s_tvalid <= 1'b0;
        while (board.peak_queue.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        while (!s_tready) @(negedge aclk);
    endtask

    task write_num_cols(logic [NUM_COLS_BITS-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.num_cols = value;
        setting_count++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return VAL_W'($signed($urandom_range(200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    // Columns cluster low and around the num_cols boundary so reads find filled columns.
    function automatic logic [COLUMN_BITS-1:0] pick_column(logic [NUM_COLS_BITS-1:0] nc);
        int span;
        int sel;
        span = (nc > COLS) ? COLS : int'(nc);
        sel  = $urandom_range(99);
        if (span == 0 || sel >= 80)
            return COLUMN_BITS'($urandom);
        if (sel < 55)
            return COLUMN_BITS'($urandom_range(((span < 16) ? span : 16) - 1));
        if (sel < 70)
            return COLUMN_BITS'(span - 1);
        return COLUMN_BITS'((span < COLS) ? span : $urandom_range(COLS - 1, COLS - 8));
    endfunction

    function automatic entry_word_t make_word(logic [NUM_COLS_BITS-1:0] nc);
        entry_word_t w;
        int sel;
        sel         = $urandom_range(99);
        w.row       = ROW_W'($urandom);
        w.column    = pick_column(nc);
        w.first     = pick_value();
        w.second    = pick_value();
        w.minus_inf = ($urandom_range(9) == 0);
        if (sel < 62) begin
            w.kind = KIND_UPDATE;
            // Equal sum on the same column as the previous update.
            if ($urandom_range(6) == 0) begin
                w.column = last_column;
                w.first  = last_second;
                w.second = last_first;
            end
            last_column = w.column;
            last_first  = w.first;
            last_second = w.second;
        end else if (sel < 94) begin
            w.kind = KIND_READ;
        end else if (sel < 97) begin
            w.kind = KIND_CLEAR;
        end else begin
            w.kind = KIND_UNUSED;
        end
        return w;
    endfunction

    task set_idling(int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 82; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 82; end
            default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
        endcase
    endtask

    // Column counts per random phase, extremes included.
    logic [NUM_COLS_BITS-1:0] phase_cols [8] = '{11'd1024, 11'd1, 11'd0, 11'd2047,
                                                 11'd16, 11'd512, 11'd1023, 11'd7};

    initial begin
        board              = new();
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = '0;
        m_tready           = 1'b0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        cycle_count        = 0;
        setting_count      = 0;
        last_column        = '0;
        last_first         = '0;
        last_second        = '0;
        set_idling(0);
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: value extremes, ties, minus infinity, unused kind and clear.
        send(KIND_READ,   10'd0,    16'd0,     32'd0,        1'b0, 32'd0);
        send(KIND_UPDATE, 10'd0,    16'd1,     32'h7fffffff, 1'b0, 32'h7fffffff);
        send(KIND_READ,   10'd0,    16'd0,     32'd0,        1'b0, 32'd0);
        send(KIND_UPDATE, 10'd0,    16'd2,     32'h7fffffff, 1'b0, 32'h7fffffff);
        send(KIND_UPDATE, 10'd1023, 16'hffff,  32'h80000000, 1'b0, 32'h80000000);
        send(KIND_READ,   10'd1023, 16'd0,     32'd0,        1'b0, 32'd0);
        send(KIND_UPDATE, 10'd1023, 16'd5,     32'h80000000, 1'b0, 32'h80000001);
        send(KIND_UPDATE, 10'd1,    16'h1234,  32'h7fffffff, 1'b1, 32'h7fffffff);
        send(KIND_READ,   10'd1,    16'd0,     32'd0,        1'b0, 32'd0);
        send(KIND_READ,   10'd1023, 16'd0,     32'd0,        1'b0, 32'd0);
        send(KIND_UNUSED, 10'd0,    16'hffff,  32'hffffffff, 1'b1, 32'hffffffff);
        send(KIND_READ,   10'd0,    16'd0,     32'd0,        1'b0, 32'd0);
        send(KIND_CLEAR,  10'd0,    16'd0,     32'd0,        1'b0, 32'd0);
        send(KIND_READ,   10'd0,    16'd0,     32'd0,        1'b0, 32'd0);
        send(KIND_READ,   10'd1023, 16'd0,     32'd0,        1'b0, 32'd0);
        send(KIND_UPDATE, 10'd2,    16'habcd,  32'hffffffff, 1'b0, 32'd0);
        send(KIND_UPDATE, 10'd2,    16'h0042,  32'd0,        1'b0, 32'd0);
        send(KIND_READ,   10'd2,    16'd0,     32'd0,        1'b0, 32'd0);

        // Narrowing num_cols drops entries beyond it but keeps stored columns.
        write_num_cols(11'd3);
        send(KIND_UPDATE, 10'd3,    16'd9,     32'd100,      1'b0, 32'd1);
        send(KIND_READ,   10'd3,    16'd0,     32'd0,        1'b0, 32'd0);
        send(KIND_READ,   10'd2,    16'd0,     32'd0,        1'b0, 32'd0);
        write_num_cols(11'd0);
        send(KIND_UPDATE, 10'd0,    16'd7,     32'd5,        1'b0, 32'd5);
        send(KIND_READ,   10'd0,    16'd0,     32'd0,        1'b0, 32'd0);
        send(KIND_READ,   10'd2,    16'd0,     32'd0,        1'b0, 32'd0);
        write_num_cols(11'd1024);
        send(KIND_READ,   10'd2,    16'd0,     32'd0,        1'b0, 32'd0);

        // Long run of clears so the clear generation wraps and the sweep runs.
        set_idling(3);
        for (int i = 0; i < 260; i++) begin
            send(KIND_CLEAR, COLUMN_BITS'($urandom), ROW_W'($urandom), $urandom,
                 1'($urandom), $urandom);
            if ($urandom_range(7) == 0)
                send(KIND_UPDATE, COLUMN_BITS'($urandom_range(7)), ROW_W'($urandom),
                     pick_value(), 1'b0, pick_value());
            if ($urandom_range(7) == 0)
                send(KIND_READ, COLUMN_BITS'($urandom_range(7)), ROW_W'($urandom), $urandom,
                     1'($urandom), $urandom);
        end
        for (int c = 0; c < 8; c++)
            send(KIND_READ, COLUMN_BITS'(c), 16'd0, 32'd0, 1'b0, 32'd0);

        // Random phases, each with its own column count and idling pattern.
        foreach (phase_cols[p]) begin
            write_num_cols(phase_cols[p]);
            set_idling(p % 4);
            repeat (48) drive_word(make_word(phase_cols[p]));
        end

        set_idling(0);
        wait_idle();
        repeat (20) @(negedge aclk);
        if (board.peak_queue.size() != 0)
            board.report_mismatch("reads left without a result");
        $display("Run covered %0d words, %0d column reads and %0d clears", board.word_count,
                 board.read_count, board.clear_count);
        $display("across %0d column-count settings and four idling patterns.",
                 setting_count + 1);
        if (board.mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
